// ===== src/yvp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yvp_pkg
// shared constants and types of the yaw perspective vertex projector
// ----------------------------------------------------------------------------
package yvp_pkg;

  // default coordinate width, q16.16
  localparam int unsigned COORD_WIDTH_DEF = 32;

  // fraction bits of the yaw cosine and sine, q2.14
  localparam int unsigned ROT_FRAC = 14;

  // quotient bits kept by the projection divider, beyond them the value saturates
  localparam int unsigned QUOT_BITS = 17;

  localparam int unsigned TRIG_W  = 16;
  localparam int unsigned HALF_W  = 12;
  localparam int unsigned FOCAL_W = 16;
  localparam int unsigned SCREEN_W = 16;
  localparam int unsigned REG_IDX_W = 3;

  // register map
  typedef enum logic [REG_IDX_W-1:0] {
    REG_CAMERA_X    = 3'd0,
    REG_CAMERA_Y    = 3'd1,
    REG_CAMERA_Z    = 3'd2,
    REG_YAW_COSINE  = 3'd3,
    REG_YAW_SINE    = 3'd4,
    REG_HALF_WIDTH  = 3'd5,
    REG_HALF_HEIGHT = 3'd6,
    REG_FOCAL_SCALE = 3'd7
  } reg_idx_e;

  localparam logic signed [TRIG_W-1:0] YAW_COSINE_RST  = 16'sd16384;
  localparam logic signed [TRIG_W-1:0] YAW_SINE_RST    = 16'sd0;
  localparam logic [HALF_W-1:0]        HALF_WIDTH_RST  = 12'd400;
  localparam logic [HALF_W-1:0]        HALF_HEIGHT_RST = 12'd300;
  localparam logic [FOCAL_W-1:0]       FOCAL_SCALE_RST = 16'd600;

endpackage

// ===== src/yvp_rotate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yvp_rotate
// three-stage translate and yaw rotation: sum, multiply, accumulate and shift
// ----------------------------------------------------------------------------
module yvp_rotate import yvp_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int unsigned XW = COORD_WIDTH + 2,
  localparam int unsigned RW = COORD_WIDTH + 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH-1:0] object_x_i,
  input  logic signed [COORD_WIDTH-1:0] object_y_i,
  input  logic signed [COORD_WIDTH-1:0] object_z_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_y_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_z_i,
  input  logic signed [COORD_WIDTH-1:0] camera_x_i,
  input  logic signed [COORD_WIDTH-1:0] camera_y_i,
  input  logic signed [COORD_WIDTH-1:0] camera_z_i,
  input  logic signed [TRIG_W-1:0]      yaw_cosine_i,
  input  logic signed [TRIG_W-1:0]      yaw_sine_i,
  output logic                          valid_o,
  output logic signed [RW-1:0]          rx_o,
  output logic signed [RW-1:0]          ry_o,
  output logic signed [XW-1:0]          z_o
);

  localparam int unsigned PW = XW + TRIG_W + 1;
  localparam int unsigned SW = PW + 1;

  logic                 v1_q, v2_q, v3_q;
  logic signed [XW-1:0] x_q, y_q, z1_q, z2_q, z3_q;
  logic signed [PW-1:0] xc_q, ys_q, yc_q, xs_q;
  logic signed [RW-1:0] rx_q, ry_q;

  logic signed [TRIG_W:0] cos_w, sin_w;
  logic signed [SW-1:0]   sum_x, sum_y;

  assign cos_w = (TRIG_W+1)'(yaw_cosine_i);
  assign sin_w = (TRIG_W+1)'(yaw_sine_i);

  // exact sums, floor shift is an arithmetic right shift
  assign sum_x = SW'(xc_q) + SW'(ys_q);
  assign sum_y = SW'(yc_q) - SW'(xs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q  <= XW'(object_x_i) + XW'(vertex_x_i) - XW'(camera_x_i);
    y_q  <= XW'(object_y_i) + XW'(vertex_y_i) - XW'(camera_y_i);
    z1_q <= XW'(object_z_i) + XW'(vertex_z_i) - XW'(camera_z_i);
    xc_q <= PW'(x_q) * PW'(cos_w);
    ys_q <= PW'(y_q) * PW'(sin_w);
    yc_q <= PW'(y_q) * PW'(cos_w);
    xs_q <= PW'(x_q) * PW'(sin_w);
    z2_q <= z1_q;
    rx_q <= RW'(sum_x >>> ROT_FRAC);
    ry_q <= RW'(sum_y >>> ROT_FRAC);
    z3_q <= z2_q;
  end

  assign valid_o = v3_q;
  assign rx_o    = rx_q;
  assign ry_o    = ry_q;
  assign z_o     = z3_q;

endmodule

// ===== src/yvp_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yvp_divider
// pipelined restoring divider, one quotient bit per stage, saturating quotient
// ----------------------------------------------------------------------------
module yvp_divider import yvp_pkg::*; #(
  parameter int unsigned NUM_W = 54,
  parameter int unsigned DEN_W = 38,
  parameter int unsigned Q_W   = QUOT_BITS,
  parameter int unsigned TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [Q_W:0]     quot_o,
  output logic [TAG_W-1:0] tag_o
);

  localparam int unsigned CW = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + Q_W;

  logic             v_q   [Q_W+1];
  logic [CW-1:0]    rem_q [Q_W+1];
  logic [DEN_W-1:0] den_q [Q_W+1];
  logic [Q_W-1:0]   quo_q [Q_W+1];
  logic             ovf_q [Q_W+1];
  logic [TAG_W-1:0] tag_q [Q_W+1];

  for (genvar gi = 0; gi <= Q_W; gi++) begin : g_stage
    localparam int unsigned SH = Q_W - gi;
    logic             v_in;
    logic [CW-1:0]    rem_in, trial;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   quo_in;
    logic             ovf_in, ge;
    logic [TAG_W-1:0] tag_in;

    if (gi == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = CW'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
      assign ovf_in = 1'b0;
      assign tag_in = tag_i;
    end else begin : g_next
      assign v_in   = v_q[gi-1];
      assign rem_in = rem_q[gi-1];
      assign den_in = den_q[gi-1];
      assign quo_in = quo_q[gi-1];
      assign ovf_in = ovf_q[gi-1];
      assign tag_in = tag_q[gi-1];
    end

    assign trial = CW'(den_in) << SH;
    assign ge    = (rem_in >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[gi] <= 1'b0;
      end else begin
        v_q[gi] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[gi] <= den_in;
      tag_q[gi] <= tag_in;
      if (gi == 0) begin
        // quotient would not fit in Q_W bits
        ovf_q[gi] <= ge;
        rem_q[gi] <= rem_in;
        quo_q[gi] <= quo_in;
      end else begin
        ovf_q[gi] <= ovf_in;
        rem_q[gi] <= ge ? (rem_in - trial) : rem_in;
        quo_q[gi] <= quo_in | (Q_W'(ge) << SH);
      end
    end
  end

  assign valid_o = v_q[Q_W];
  assign quot_o  = ovf_q[Q_W] ? {1'b1, {Q_W{1'b0}}} : {1'b0, quo_q[Q_W]};
  assign tag_o   = tag_q[Q_W];

endmodule

// ===== src/yaw_perspective_vertex_projector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yaw_perspective_vertex_projector
// projects one world-space vertex to saturated screen coordinates
// ----------------------------------------------------------------------------
// usage
//   an item (object origin plus vertex offset, q16.16) is taken at a rising
//   edge with start high and busy low; busy is always low, so an item can be
//   offered every cycle
//   the result shows on visible_o, screen_x_o, screen_y_o for exactly one
//   cycle, marked by result_valid_o; the receiver cannot stall it
//   the pipeline registers are, in order: input sum, products, rotation sum,
//   projection prep, 18 divider stages (one quotient bit per stage plus
//   overflow check), output register
//   throughput is one item per cycle; the rate is set by the fully
//   pipelined restoring divider, one compare and subtract per stage
//   camera, yaw, half size and focal scale are written through wr_en_i,
//   wr_index_i, wr_data_i while no item is in flight (user rule, unenforced)
//   reset clears all pipeline valid bits and loads the register defaults
//   (camera at the origin, yaw zero, 400 by 300 half size, focal 600)
// ----------------------------------------------------------------------------
module yaw_perspective_vertex_projector import yvp_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item channel
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] object_x_i,
  input  logic signed [COORD_WIDTH-1:0] object_y_i,
  input  logic signed [COORD_WIDTH-1:0] object_z_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_y_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_z_i,
  // result channel
  output logic                          result_valid_o,
  output logic                          visible_o,
  output logic signed [SCREEN_W-1:0]    screen_x_o,
  output logic signed [SCREEN_W-1:0]    screen_y_o,
  // register write port
  input  logic                          wr_en_i,
  input  logic [REG_IDX_W-1:0]          wr_index_i,
  input  logic [COORD_WIDTH-1:0]        wr_data_i
);

  localparam int unsigned XW    = COORD_WIDTH + 2;
  localparam int unsigned RW    = COORD_WIDTH + 6;
  localparam int unsigned NUM_W = RW + FOCAL_W;
  localparam int unsigned SUM_W = QUOT_BITS + 3;

  // configuration registers
  logic signed [COORD_WIDTH-1:0] camera_x_q, camera_y_q, camera_z_q;
  logic signed [TRIG_W-1:0]      yaw_cosine_q, yaw_sine_q;
  logic [HALF_W-1:0]             half_width_q, half_height_q;
  logic [FOCAL_W-1:0]            focal_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      camera_x_q    <= '0;
      camera_y_q    <= '0;
      camera_z_q    <= '0;
      yaw_cosine_q  <= YAW_COSINE_RST;
      yaw_sine_q    <= YAW_SINE_RST;
      half_width_q  <= HALF_WIDTH_RST;
      half_height_q <= HALF_HEIGHT_RST;
      focal_scale_q <= FOCAL_SCALE_RST;
    end else if (wr_en_i) begin
      unique case (reg_idx_e'(wr_index_i))
        REG_CAMERA_X:    camera_x_q    <= wr_data_i;
        REG_CAMERA_Y:    camera_y_q    <= wr_data_i;
        REG_CAMERA_Z:    camera_z_q    <= wr_data_i;
        REG_YAW_COSINE:  yaw_cosine_q  <= wr_data_i[TRIG_W-1:0];
        REG_YAW_SINE:    yaw_sine_q    <= wr_data_i[TRIG_W-1:0];
        REG_HALF_WIDTH:  half_width_q  <= wr_data_i[HALF_W-1:0];
        REG_HALF_HEIGHT: half_height_q <= wr_data_i[HALF_W-1:0];
        REG_FOCAL_SCALE: focal_scale_q <= wr_data_i[FOCAL_W-1:0];
        default: ;
      endcase
    end
  end

  // the pipeline never pushes back
  assign busy = 1'b0;

  // translate and rotate, three stages
  logic                 rot_valid;
  logic signed [RW-1:0] rot_rx, rot_ry;
  logic signed [XW-1:0] rot_z;

  yvp_rotate #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_rotate (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (start),
    .object_x_i   (object_x_i),
    .object_y_i   (object_y_i),
    .object_z_i   (object_z_i),
    .vertex_x_i   (vertex_x_i),
    .vertex_y_i   (vertex_y_i),
    .vertex_z_i   (vertex_z_i),
    .camera_x_i   (camera_x_q),
    .camera_y_i   (camera_y_q),
    .camera_z_i   (camera_z_q),
    .yaw_cosine_i (yaw_cosine_q),
    .yaw_sine_i   (yaw_sine_q),
    .valid_o      (rot_valid),
    .rx_o         (rot_rx),
    .ry_o         (rot_ry),
    .z_o          (rot_z)
  );

  // projection prep: visibility, magnitudes scaled by focal
  logic signed [RW-1:0] z_ext;
  logic [RW-1:0]        mag_x, mag_z;
  logic                 vis_d;

  assign z_ext = RW'(rot_z);
  assign mag_x = rot_rx[RW-1] ? RW'(-rot_rx) : RW'(rot_rx);
  assign mag_z = z_ext[RW-1] ? RW'(-z_ext) : RW'(z_ext);
  assign vis_d = (rot_ry > 0);

  logic             prep_valid_q;
  logic [NUM_W-1:0] num_x_q, num_z_q;
  logic [RW-1:0]    den_q;
  logic             vis_q, neg_x_q, neg_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_valid_q <= 1'b0;
    end else begin
      prep_valid_q <= rot_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    num_x_q <= NUM_W'(mag_x) * NUM_W'(focal_scale_q);
    num_z_q <= NUM_W'(mag_z) * NUM_W'(focal_scale_q);
    // a hidden vertex divides by one, its quotient is dropped
    den_q   <= vis_d ? RW'(rot_ry) : RW'(1);
    vis_q   <= vis_d;
    neg_x_q <= rot_rx[RW-1];
    neg_z_q <= z_ext[RW-1];
  end

  // two dividers side by side
  logic                 div_valid, div_z_valid;
  logic [QUOT_BITS:0]   quot_x, quot_z;
  logic [1:0]           tag_x;
  logic                 tag_z;

  yvp_divider #(
    .NUM_W (NUM_W),
    .DEN_W (RW),
    .Q_W   (QUOT_BITS),
    .TAG_W (2)
  ) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid_q),
    .num_i   (num_x_q),
    .den_i   (den_q),
    .tag_i   ({vis_q, neg_x_q}),
    .valid_o (div_valid),
    .quot_o  (quot_x),
    .tag_o   (tag_x)
  );

  yvp_divider #(
    .NUM_W (NUM_W),
    .DEN_W (RW),
    .Q_W   (QUOT_BITS),
    .TAG_W (1)
  ) u_div_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid_q),
    .num_i   (num_z_q),
    .den_i   (den_q),
    .tag_i   (neg_z_q),
    .valid_o (div_z_valid),
    .quot_o  (quot_z),
    .tag_o   (tag_z)
  );

  // sign, add half size, saturate to 16 bits
  function automatic logic signed [SCREEN_W-1:0] place(
    input logic [QUOT_BITS:0] quot,
    input logic               neg,
    input logic [HALF_W-1:0]  half
  );
    logic signed [SUM_W-1:0] mag, v;
    mag = SUM_W'(quot);
    v   = (neg ? mag : -mag) + SUM_W'(half);
    if (v > SUM_W'(32767)) begin
      place = 16'sh7fff;
    end else if (v < -SUM_W'(32768)) begin
      place = 16'sh8000;
    end else begin
      place = v[SCREEN_W-1:0];
    end
  endfunction

  logic                       out_valid_q, visible_q;
  logic signed [SCREEN_W-1:0] screen_x_q, screen_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      // both dividers run in lockstep
      out_valid_q <= div_valid & div_z_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    visible_q  <= tag_x[1];
    screen_x_q <= tag_x[1] ? place(quot_x, tag_x[0], half_width_q) : '0;
    screen_y_q <= tag_x[1] ? place(quot_z, tag_z, half_height_q) : '0;
  end

  assign result_valid_o = out_valid_q;
  assign visible_o      = visible_q;
  assign screen_x_o     = screen_x_q;
  assign screen_y_o     = screen_y_q;

endmodule
